[src/cns_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cns_pkg
// shared types, codes and twister helpers of the csr neighbor sampler
// ----------------------------------------------------------------------------
package cns_pkg;

    localparam int unsigned MAX_NODES_DEF  = 65536;
    localparam int unsigned MAX_EDGES_DEF  = 262144;
    localparam int unsigned POOL_DEPTH_DEF = 1024;
    localparam int unsigned MAX_SAMPLE_DEF = 64;

    // configuration register indexes
    localparam logic CFG_USER_COUNT = 1'b0;
    localparam logic CFG_ITEM_COUNT = 1'b1;

    localparam int unsigned TW_N = 312;
    localparam int unsigned TW_M = 156;
    localparam logic [63:0] TW_MATRIX = 64'hB502_6F5A_A966_19E9;
    localparam logic [63:0] TW_UPPER  = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] TW_LOWER  = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] TW_SEED_MUL = 64'd6364136223846793005;

    typedef enum logic [1:0] {
        OP_WR_OFFSET   = 2'd0,
        OP_WR_NEIGHBOR = 2'd1,
        OP_SAMPLE      = 2'd2,
        OP_UNUSED      = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        STAT_NEIGHBOR = 3'd0,
        STAT_EMPTY    = 3'd1,
        STAT_RANGE    = 3'd2,
        STAT_ACK      = 3'd3,
        STAT_TOOBIG   = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_OFF_A,
        ST_OFF_B,
        ST_OFF_C,
        ST_DECIDE,
        ST_LIST_RD,
        ST_LIST_DT,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_SEED_0,
        ST_SEED,
        ST_LIM,
        ST_DIV,
        ST_RND_CHK,
        ST_RND_RD,
        ST_RND_DT,
        ST_REFILL,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_SWAP_C,
        ST_SWAP_D,
        ST_EMIT_RD,
        ST_EMIT_DT,
        ST_OUT
    } t_state;

    // output tempering of one twister word
    function automatic logic [63:0] tw_temper(input logic [63:0] w);
        logic [63:0] x;
        x = w;
        x = x ^ ((x >> 29) & 64'h5555_5555_5555_5555);
        x = x ^ ((x << 17) & 64'h71D6_7FFF_EDA6_0000);
        x = x ^ ((x << 37) & 64'hFFF7_EEE0_0000_0000);
        x = x ^ (x >> 43);
        return x;
    endfunction

    // one word of the state regeneration
    function automatic logic [63:0] tw_twist(input logic [63:0] wi,
                                             input logic [63:0] wi1,
                                             input logic [63:0] wm);
        logic [63:0] y;
        logic [63:0] v;
        y = (wi & TW_UPPER) | (wi1 & TW_LOWER);
        v = wm ^ (y >> 1);
        if (y[0]) begin
            v = v ^ TW_MATRIX;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

[src/csr_neighbor_sampler.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csr_neighbor_sampler
// csr graph store with seeded neighbor sampling by partial fisher-yates
// ----------------------------------------------------------------------------
// flow: writes, unused opcodes and range misses answer in the cycle after the beat;
//   empty and oversize answers follow the offset reads; whole lists one read per neighbor
// shuffled: offset reads, pool copy, seeding on one 32x32 multiplier, state
//   regenerations as needed, a bit-serial remainder per step, then the outputs,
//   all held by output stalls; input stalled while busy; reset: synchronous active
//   low, clears control, counts, output valid
// ----------------------------------------------------------------------------
module csr_neighbor_sampler #(
    parameter int unsigned MAX_NODES  = cns_pkg::MAX_NODES_DEF,
    parameter int unsigned MAX_EDGES  = cns_pkg::MAX_EDGES_DEF,
    parameter int unsigned POOL_DEPTH = cns_pkg::POOL_DEPTH_DEF,
    parameter int unsigned MAX_SAMPLE = cns_pkg::MAX_SAMPLE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config port
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [16:0] i_cfg_data,
    // request channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [17:0] i_table_address,
    input  wire logic [18:0] i_table_data,
    input  wire logic [15:0] i_node,
    input  wire logic [6:0]  i_sample_count,
    input  wire logic [63:0] i_seed,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_neighbor,
    output logic             o_last,
    output logic [2:0]       o_status
);

    import cns_pkg::*;

    localparam int unsigned OAW = $clog2(MAX_NODES + 1);
    localparam int unsigned NAW = $clog2(MAX_EDGES);
    localparam int unsigned PAW = $clog2(POOL_DEPTH);
    localparam int unsigned NW  = $clog2(POOL_DEPTH + 1);
    localparam int unsigned TAW = $clog2(TW_N);

    // ---------------------------------------------------------------- state
    t_state       r_state, n_state, r_ret, n_ret;
    logic [16:0]  r_user, r_item;
    logic [15:0]  r_node, n_node;
    logic [6:0]   r_k, n_k;
    logic [63:0]  r_seed, n_seed;
    logic [18:0]  r_begin, n_begin;
    logic [18:0]  r_degree, n_degree;
    logic [18:0]  r_idx, n_idx;
    logic         r_oor, n_oor;
    logic [NW-1:0]  r_n, n_n;
    logic [PAW-1:0] r_j, n_j;
    logic [15:0]  r_pi, n_pi;
    // twister
    logic [8:0]   r_pos, n_pos;
    logic [8:0]   r_ti, n_ti;
    logic [1:0]   r_ph, n_ph;
    logic [63:0]  r_prev, n_prev;
    logic [63:0]  r_acc, n_acc;
    logic [63:0]  r_prod;
    logic [63:0]  r_wi, n_wi;
    logic [63:0]  r_wi1, n_wi1;
    logic [63:0]  r_limit, n_limit;
    // remainder unit
    logic [63:0]   r_dvd, n_dvd;
    logic [NW-1:0] r_rem, n_rem;
    logic [5:0]    r_dcnt, n_dcnt;
    logic          r_dmod, n_dmod;
    // output slot
    logic         r_ov, n_ov;
    logic [15:0]  r_on, n_on;
    logic         r_ol, n_ol;
    logic [2:0]   r_os, n_os;

    // ---------------------------------------------------------------- memories
    logic            off_we, off_re;
    logic [OAW-1:0]  off_waddr, off_raddr;
    logic [18:0]     off_rdata;
    logic            nb_we, nb_re;
    logic [NAW-1:0]  nb_waddr, nb_raddr;
    logic [15:0]     nb_rdata;
    logic            pl_we, pl_re;
    logic [PAW-1:0]  pl_waddr, pl_raddr;
    logic [15:0]     pl_wdata, pl_rdata;
    logic            tw_we, tw_re;
    logic [TAW-1:0]  tw_waddr, tw_raddr;
    logic [63:0]     tw_wdata, tw_rdata;

    cns_ram #(.WIDTH(19), .DEPTH(MAX_NODES + 1)) u_offset_ram (
        .i_clk(i_clk), .i_we(off_we), .i_waddr(off_waddr), .i_wdata(i_table_data),
        .i_re(off_re), .i_raddr(off_raddr), .o_rdata(off_rdata)
    );

    cns_ram #(.WIDTH(16), .DEPTH(MAX_EDGES)) u_neighbor_ram (
        .i_clk(i_clk), .i_we(nb_we), .i_waddr(nb_waddr), .i_wdata(i_table_data[15:0]),
        .i_re(nb_re), .i_raddr(nb_raddr), .o_rdata(nb_rdata)
    );

    cns_ram #(.WIDTH(16), .DEPTH(POOL_DEPTH)) u_pool_ram (
        .i_clk(i_clk), .i_we(pl_we), .i_waddr(pl_waddr), .i_wdata(pl_wdata),
        .i_re(pl_re), .i_raddr(pl_raddr), .o_rdata(pl_rdata)
    );

    cns_ram #(.WIDTH(64), .DEPTH(TW_N)) u_twister_ram (
        .i_clk(i_clk), .i_we(tw_we), .i_waddr(tw_waddr), .i_wdata(tw_wdata),
        .i_re(tw_re), .i_raddr(tw_raddr), .o_rdata(tw_rdata)
    );

    // ---------------------------------------------------------------- shared multiplier
    // one 32x32 product per cycle, used for the seeding recurrence
    logic [63:0] seed_x;
    logic [31:0] mul_a, mul_b;

    assign seed_x = r_prev ^ (r_prev >> 62);

    always_comb begin
        case (r_ph)
            2'd0:    begin mul_a = seed_x[31:0];  mul_b = TW_SEED_MUL[31:0];  end
            2'd1:    begin mul_a = seed_x[31:0];  mul_b = TW_SEED_MUL[63:32]; end
            default: begin mul_a = seed_x[63:32]; mul_b = TW_SEED_MUL[31:0];  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
    end

    // ---------------------------------------------------------------- remainder step
    // restoring remainder, one dividend bit per cycle
    logic [NW:0]   div_t;
    logic [NW-1:0] div_rem;

    assign div_t = {r_rem, r_dvd[63]};

    always_comb begin
        if (div_t >= {1'b0, r_n}) begin
            div_rem = NW'(div_t - {1'b0, r_n});
        end else begin
            div_rem = NW'(div_t);
        end
    end

    // ---------------------------------------------------------------- helpers
    logic         in_accept;
    logic [17:0]  node_total;
    logic         node_oor;
    logic [19:0]  nb_index;
    logic         nb_oor;
    logic [63:0]  rnd;
    logic [18:0]  end_off;
    logic [18:0]  j_full;
    logic [8:0]   ti_next1, ti_mid;

    assign in_accept  = i_valid && !o_stall;
    assign node_total = 18'(r_user) + 18'(r_item);
    assign node_oor   = (32'(i_node) >= 32'(node_total)) || (32'(i_node) >= MAX_NODES);
    assign nb_index   = 20'(r_begin) + 20'(r_idx);
    assign nb_oor     = 32'(nb_index) >= MAX_EDGES;
    assign rnd        = tw_temper(tw_rdata);
    assign end_off    = off_rdata;
    assign j_full     = r_idx + 19'(div_rem);
    assign ti_next1   = (32'(r_ti) == TW_N - 1) ? 9'd0 : r_ti + 9'd1;
    assign ti_mid     = (32'(r_ti) < TW_M) ? 9'(r_ti + 9'(TW_M)) : 9'(r_ti - 9'(TW_M));

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_node   = r_node;
        n_k      = r_k;
        n_seed   = r_seed;
        n_begin  = r_begin;
        n_degree = r_degree;
        n_idx    = r_idx;
        n_oor    = r_oor;
        n_n      = r_n;
        n_j      = r_j;
        n_pi     = r_pi;
        n_pos    = r_pos;
        n_ti     = r_ti;
        n_ph     = r_ph;
        n_prev   = r_prev;
        n_acc    = r_acc;
        n_wi     = r_wi;
        n_wi1    = r_wi1;
        n_limit  = r_limit;
        n_dvd    = r_dvd;
        n_rem    = r_rem;
        n_dcnt   = r_dcnt;
        n_dmod   = r_dmod;
        n_ov     = r_ov;
        n_on     = r_on;
        n_ol     = r_ol;
        n_os     = r_os;

        off_we    = 1'b0;
        off_waddr = OAW'(i_table_address);
        off_re    = 1'b0;
        off_raddr = OAW'(r_node);
        nb_we     = 1'b0;
        nb_waddr  = NAW'(i_table_address);
        nb_re     = 1'b0;
        nb_raddr  = NAW'(nb_index);
        pl_we     = 1'b0;
        pl_waddr  = PAW'(r_idx);
        pl_wdata  = r_oor ? 16'd0 : nb_rdata;
        pl_re     = 1'b0;
        pl_raddr  = PAW'(r_idx);
        tw_we     = 1'b0;
        tw_waddr  = TAW'(r_ti);
        tw_wdata  = r_seed;
        tw_re     = 1'b0;
        tw_raddr  = TAW'(r_pos);

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_node = i_node;
                    n_seed = i_seed;
                    n_k    = (i_sample_count > 7'(MAX_SAMPLE)) ? 7'(MAX_SAMPLE)
                                                               : i_sample_count;
                    n_on   = 16'd0;
                    n_ol   = 1'b1;
                    n_ret  = ST_IDLE;
                    case (t_opcode'(i_opcode))
                        OP_WR_OFFSET: begin
                            off_we  = 32'(i_table_address) < MAX_NODES + 1;
                            n_os    = STAT_ACK;
                            n_ov    = 1'b1;
                            n_state = ST_OUT;
                        end
                        OP_WR_NEIGHBOR: begin
                            nb_we   = 32'(i_table_address) < MAX_EDGES;
                            n_os    = STAT_ACK;
                            n_ov    = 1'b1;
                            n_state = ST_OUT;
                        end
                        OP_SAMPLE: begin
                            if (node_oor) begin
                                n_os    = STAT_RANGE;
                                n_ov    = 1'b1;
                                n_state = ST_OUT;
                            end else begin
                                n_state = ST_OFF_A;
                            end
                        end
                        default: begin
                            n_os    = STAT_ACK;
                            n_ov    = 1'b1;
                            n_state = ST_OUT;
                        end
                    endcase
                end
            end

            ST_OFF_A: begin
                off_re  = 1'b1;
                n_state = ST_OFF_B;
            end

            ST_OFF_B: begin
                n_begin   = off_rdata;
                off_re    = 1'b1;
                off_raddr = OAW'(17'(r_node) + 17'd1);
                n_state   = ST_OFF_C;
            end

            ST_OFF_C: begin
                n_degree = (end_off > r_begin) ? end_off - r_begin : 19'd0;
                n_idx    = 19'd0;
                n_state  = ST_DECIDE;
            end

            ST_DECIDE: begin
                n_on  = 16'd0;
                n_ol  = 1'b1;
                n_ret = ST_IDLE;
                if (r_k == 7'd0 || r_degree == 19'd0) begin
                    n_os    = STAT_EMPTY;
                    n_ov    = 1'b1;
                    n_state = ST_OUT;
                end else if (19'(r_k) >= r_degree) begin
                    n_state = ST_LIST_RD;
                end else if (32'(r_degree) > POOL_DEPTH) begin
                    n_os    = STAT_TOOBIG;
                    n_ov    = 1'b1;
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_COPY_RD;
                end
            end

            // whole list in table order
            ST_LIST_RD: begin
                nb_re   = !nb_oor;
                n_oor   = nb_oor;
                n_state = ST_LIST_DT;
            end

            ST_LIST_DT: begin
                n_on    = r_oor ? 16'd0 : nb_rdata;
                n_ol    = (r_idx + 19'd1 == r_degree);
                n_os    = STAT_NEIGHBOR;
                n_ov    = 1'b1;
                n_ret   = (r_idx + 19'd1 == r_degree) ? ST_IDLE : ST_LIST_RD;
                n_state = ST_OUT;
            end

            // scratch copy into the pool
            ST_COPY_RD: begin
                nb_re   = !nb_oor;
                n_oor   = nb_oor;
                n_state = ST_COPY_WR;
            end

            ST_COPY_WR: begin
                pl_we = 1'b1;
                n_idx = r_idx + 19'd1;
                if (r_idx + 19'd1 == r_degree) begin
                    n_state = ST_SEED_0;
                end else begin
                    n_state = ST_COPY_RD;
                end
            end

            // seeding: w[i] = mul * (p ^ (p >> 62)) + i
            ST_SEED_0: begin
                tw_we    = 1'b1;
                tw_waddr = TAW'(0);
                tw_wdata = r_seed;
                n_prev   = r_seed;
                n_ti     = 9'd1;
                n_ph     = 2'd0;
                n_state  = ST_SEED;
            end

            ST_SEED: begin
                n_ph = r_ph + 2'd1;
                case (r_ph)
                    2'd0: n_acc = 64'd0;
                    2'd1: n_acc = r_prod;
                    2'd2: n_acc = r_acc + {r_prod[31:0], 32'd0};
                    default: begin
                        tw_we    = 1'b1;
                        tw_wdata = r_acc + {r_prod[31:0], 32'd0} + 64'(r_ti);
                        n_prev   = tw_wdata;
                        n_ti     = r_ti + 9'd1;
                        if (32'(r_ti) == TW_N - 1) begin
                            n_pos   = 9'(TW_N);
                            n_idx   = 19'd0;
                            n_state = ST_LIM;
                        end
                    end
                endcase
            end

            // rejection limit for the current range
            ST_LIM: begin
                n_n     = NW'(r_degree - r_idx);
                n_dvd   = '1;
                n_rem   = '0;
                n_dcnt  = 6'd0;
                n_dmod  = 1'b0;
                n_state = ST_DIV;
            end

            ST_DIV: begin
                n_dvd  = {r_dvd[62:0], 1'b0};
                n_rem  = div_rem;
                n_dcnt = r_dcnt + 6'd1;
                if (r_dcnt == 6'd63) begin
                    if (!r_dmod) begin
                        n_limit = 64'hFFFF_FFFF_FFFF_FFFF - 64'(div_rem);
                        n_state = ST_RND_CHK;
                    end else begin
                        n_j     = (j_full >= r_degree) ? PAW'(r_degree - 19'd1)
                                                       : PAW'(j_full);
                        n_state = ST_SWAP_A;
                    end
                end
            end

            ST_RND_CHK: begin
                if (32'(r_pos) >= TW_N) begin
                    n_ti    = 9'd0;
                    n_ph    = 2'd0;
                    n_state = ST_REFILL;
                end else begin
                    n_state = ST_RND_RD;
                end
            end

            ST_RND_RD: begin
                tw_re   = 1'b1;
                n_pos   = r_pos + 9'd1;
                n_state = ST_RND_DT;
            end

            ST_RND_DT: begin
                if (rnd >= r_limit) begin
                    n_state = ST_RND_CHK;
                end else begin
                    n_dvd   = rnd;
                    n_rem   = '0;
                    n_dcnt  = 6'd0;
                    n_dmod  = 1'b1;
                    n_state = ST_DIV;
                end
            end

            // state regeneration, in place, three reads and one write a word
            ST_REFILL: begin
                n_ph = r_ph + 2'd1;
                case (r_ph)
                    2'd0: begin
                        tw_re    = 1'b1;
                        tw_raddr = TAW'(r_ti);
                    end
                    2'd1: begin
                        n_wi     = tw_rdata;
                        tw_re    = 1'b1;
                        tw_raddr = TAW'(ti_next1);
                    end
                    2'd2: begin
                        n_wi1    = tw_rdata;
                        tw_re    = 1'b1;
                        tw_raddr = TAW'(ti_mid);
                    end
                    default: begin
                        tw_we    = 1'b1;
                        tw_wdata = tw_twist(r_wi, r_wi1, tw_rdata);
                        n_ti     = r_ti + 9'd1;
                        if (32'(r_ti) == TW_N - 1) begin
                            n_pos   = 9'd0;
                            n_state = ST_RND_RD;
                        end
                    end
                endcase
            end

            // swap pool[i] and pool[j]
            ST_SWAP_A: begin
                pl_re   = 1'b1;
                n_state = ST_SWAP_B;
            end

            ST_SWAP_B: begin
                n_pi     = pl_rdata;
                pl_re    = 1'b1;
                pl_raddr = r_j;
                n_state  = ST_SWAP_C;
            end

            ST_SWAP_C: begin
                pl_we    = 1'b1;
                pl_wdata = pl_rdata;
                n_state  = ST_SWAP_D;
            end

            ST_SWAP_D: begin
                pl_we    = 1'b1;
                pl_waddr = r_j;
                pl_wdata = r_pi;
                n_idx    = r_idx + 19'd1;
                if (r_idx + 19'd1 == 19'(r_k)) begin
                    n_idx   = 19'd0;
                    n_state = ST_EMIT_RD;
                end else begin
                    n_state = ST_LIM;
                end
            end

            // first k pool entries out
            ST_EMIT_RD: begin
                pl_re   = 1'b1;
                n_state = ST_EMIT_DT;
            end

            ST_EMIT_DT: begin
                n_on    = pl_rdata;
                n_ol    = (r_idx + 19'd1 == 19'(r_k));
                n_os    = STAT_NEIGHBOR;
                n_ov    = 1'b1;
                n_ret   = (r_idx + 19'd1 == 19'(r_k)) ? ST_IDLE : ST_EMIT_RD;
                n_state = ST_OUT;
            end

            // hold the result beat until taken
            ST_OUT: begin
                if (!i_stall) begin
                    n_ov    = 1'b0;
                    n_idx   = r_idx + 19'd1;
                    n_state = r_ret;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_user  <= 17'd0;
            r_item  <= 17'd0;
            r_pos   <= 9'd0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_pos   <= n_pos;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_ITEM_COUNT) begin
                    r_item <= i_cfg_data;
                end else begin
                    r_user <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_node   <= n_node;
        r_k      <= n_k;
        r_seed   <= n_seed;
        r_begin  <= n_begin;
        r_degree <= n_degree;
        r_idx    <= n_idx;
        r_oor    <= n_oor;
        r_n      <= n_n;
        r_j      <= n_j;
        r_pi     <= n_pi;
        r_ti     <= n_ti;
        r_ph     <= n_ph;
        r_prev   <= n_prev;
        r_acc    <= n_acc;
        r_wi     <= n_wi;
        r_wi1    <= n_wi1;
        r_limit  <= n_limit;
        r_dvd    <= n_dvd;
        r_rem    <= n_rem;
        r_dcnt   <= n_dcnt;
        r_dmod   <= n_dmod;
        r_on     <= n_on;
        r_ol     <= n_ol;
        r_os     <= n_os;
    end

    assign o_stall    = (r_state != ST_IDLE);
    assign o_valid    = r_ov;
    assign o_neighbor = r_on;
    assign o_last     = r_ol;
    assign o_status   = r_os;

endmodule
`default_nettype wire

[src/cns_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cns_ram
// simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module cns_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

[test/csr_neighbor_sampler_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csr_neighbor_sampler_tb
// self-checking bench for the csr neighbor sampler
// ----------------------------------------------------------------------------
// builds small csr graphs through table writes and fires sample requests at
// them under several node-count settings. a local copy of the tables and of
// the 64-bit twister predicts every result beat, which is checked in order.
// ----------------------------------------------------------------------------
module csr_neighbor_sampler_tb;
    import cns_pkg::*;

    localparam int unsigned NODE_LIMIT = 65536;
    localparam int unsigned EDGE_LIMIT = 262144;
    localparam int unsigned POOL_SIZE  = 1024;
    localparam int unsigned K_LIMIT    = 64;
    localparam int unsigned NB_SPAN    = 96;   // neighbor entries written by the bench
    localparam int unsigned TWN        = 312;
    localparam int unsigned TWM        = 156;

    typedef struct {
        t_opcode     op;
        logic [17:0] addr;
        logic [18:0] data;
        logic [15:0] node;
        logic [6:0]  k;
        logic [63:0] seed;
    } t_req;

    typedef struct {
        logic [15:0] neighbor;
        logic        last;
        t_status     status;
    } t_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [16:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_opcode;
    logic [17:0] i_table_address;
    logic [18:0] i_table_data;
    logic [15:0] i_node;
    logic [6:0]  i_sample_count;
    logic [63:0] i_seed;
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_neighbor;
    logic        o_last;
    logic [2:0]  o_status;

    csr_neighbor_sampler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_opcode(i_opcode), .i_table_address(i_table_address),
        .i_table_data(i_table_data), .i_node(i_node),
        .i_sample_count(i_sample_count), .i_seed(i_seed),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_neighbor(o_neighbor), .o_last(o_last), .o_status(o_status)
    );

    // request beats waiting for the driver, result beats waiting for the dut
    t_req  pending_reqs[$];
    t_beat sampled_beats[$];

    // predictor copy of the block
    logic [16:0] pr_users;
    logic [16:0] pr_items;
    logic [18:0] pr_offsets[int];
    logic [15:0] pr_neighbors[int];
    logic [15:0] pr_pool[POOL_SIZE];
    logic [63:0] tw_words[TWN];
    int unsigned tw_pos;

    // generator view of what has been written, used to keep reads legal
    logic [18:0] gen_offsets[int];
    bit          gen_nb_written[int];
    int unsigned gen_count;

    int send_idle_pct;
    int recv_idle_pct;
    bit beat_taken;
    int mismatches;
    int n_requests;
    int n_results;
    int n_shuffled;
    int n_phases;
    t_req drv_req;

    // ---------------------------------------------------------------- twister
    function automatic void twister_seed(input logic [63:0] s);
        logic [63:0] p;
        tw_words[0] = s;
        for (int i = 1; i < TWN; i++) begin
            p = tw_words[i-1];
            tw_words[i] = 64'd6364136223846793005 * (p ^ (p >> 62)) + 64'(i);
        end
        tw_pos = TWN;
    endfunction

    function automatic logic [63:0] twister_next();
        logic [63:0] y;
        logic [63:0] x;
        if (tw_pos >= TWN) begin
            for (int i = 0; i < TWN; i++) begin
                y = (tw_words[i] & 64'hFFFF_FFFF_8000_0000)
                  | (tw_words[(i + 1) % TWN] & 64'h0000_0000_7FFF_FFFF);
                x = tw_words[(i + TWM) % TWN] ^ (y >> 1);
                if (y[0]) begin
                    x = x ^ 64'hB502_6F5A_A966_19E9;
                end
                tw_words[i] = x;
            end
            tw_pos = 0;
        end
        x = tw_words[tw_pos];
        tw_pos++;
        x ^= (x >> 29) & 64'h5555_5555_5555_5555;
        x ^= (x << 17) & 64'h71D6_7FFF_EDA6_0000;
        x ^= (x << 37) & 64'hFFF7_EEE0_0000_0000;
        x ^= x >> 43;
        return x;
    endfunction

    // uniform draw below n by rejection
    function automatic logic [63:0] fair_draw(input logic [63:0] n);
        logic [63:0] lim;
        logic [63:0] s;
        lim = ({64{1'b1}} / n) * n;
        s = twister_next();
        while (s >= lim) begin
            s = twister_next();
        end
        return s % n;
    endfunction

    function automatic logic [15:0] neighbor_at(input int unsigned idx);
        if (idx < EDGE_LIMIT && pr_neighbors.exists(idx)) begin
            return pr_neighbors[idx];
        end
        return 16'd0;
    endfunction

    function automatic void expect_beat(input logic [15:0] nb, input logic lst,
                                        input t_status st);
        t_beat b;
        b.neighbor = nb;
        b.last     = lst;
        b.status   = st;
        sampled_beats.insert(sampled_beats.size(), b);
    endfunction

    // work out every result beat caused by one accepted request
    function automatic void predict_samples(input t_req r);
        int unsigned cnt;
        int unsigned kk;
        int unsigned lo;
        int unsigned hi;
        int unsigned deg;
        int unsigned j;
        logic [15:0] t;
        n_requests++;
        case (r.op)
            OP_WR_OFFSET: begin
                if (r.addr <= NODE_LIMIT) begin
                    pr_offsets[r.addr] = r.data;
                end
                expect_beat(16'd0, 1'b1, STAT_ACK);
            end
            OP_WR_NEIGHBOR: begin
                pr_neighbors[r.addr] = r.data[15:0];
                expect_beat(16'd0, 1'b1, STAT_ACK);
            end
            OP_UNUSED: expect_beat(16'd0, 1'b1, STAT_ACK);
            default: begin
                cnt = pr_users + pr_items;
                if (cnt > NODE_LIMIT) begin
                    cnt = NODE_LIMIT;
                end
                kk = (r.k > K_LIMIT) ? K_LIMIT : r.k;
                lo = pr_offsets.exists(r.node) ? pr_offsets[r.node] : 0;
                hi = pr_offsets.exists(r.node + 1) ? pr_offsets[r.node + 1] : 0;
                deg = (hi > lo) ? hi - lo : 0;
                if (r.node >= cnt) begin
                    expect_beat(16'd0, 1'b1, STAT_RANGE);
                end else if (kk == 0 || deg == 0) begin
                    expect_beat(16'd0, 1'b1, STAT_EMPTY);
                end else if (kk >= deg) begin
                    for (int i = 0; i < deg; i++) begin
                        expect_beat(neighbor_at(lo + i), i + 1 == deg, STAT_NEIGHBOR);
                    end
                end else if (deg > POOL_SIZE) begin
                    expect_beat(16'd0, 1'b1, STAT_TOOBIG);
                end else begin
                    n_shuffled++;
                    for (int i = 0; i < deg; i++) begin
                        pr_pool[i] = neighbor_at(lo + i);
                    end
                    twister_seed(r.seed);
                    for (int i = 0; i < kk; i++) begin
                        j = i + int'(fair_draw(64'(deg - i)));
                        if (j >= deg) begin
                            j = deg - 1;
                        end
                        t = pr_pool[i];
                        pr_pool[i] = pr_pool[j];
                        pr_pool[j] = t;
                    end
                    for (int i = 0; i < kk; i++) begin
                        expect_beat(pr_pool[i], i + 1 == kk, STAT_NEIGHBOR);
                    end
                end
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- clock, reset
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- driver
    // request side and stall of the result side change on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || beat_taken) begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                drv_req = pending_reqs.pop_front();
                i_valid         <= 1'b1;
                i_opcode        <= drv_req.op;
                i_table_address <= drv_req.addr;
                i_table_data    <= drv_req.data;
                i_node          <= drv_req.node;
                i_sample_count  <= drv_req.k;
                i_seed          <= drv_req.seed;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= (recv_idle_pct > 0) && ($urandom_range(0, 99) < recv_idle_pct);
    end

    // ---------------------------------------------------------------- monitor
    // request beats feed the predictor, result beats are checked in order
    always @(posedge i_clk) begin
        t_beat got;
        t_beat want;
        t_req  r;
        if (!i_rst_n) begin
            beat_taken = 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_USER_COUNT) begin
                    pr_users = i_cfg_data;
                end else begin
                    pr_items = i_cfg_data;
                end
            end
            beat_taken = i_valid && !o_stall;
            if (beat_taken) begin
                r.op   = t_opcode'(i_opcode);
                r.addr = i_table_address;
                r.data = i_table_data;
                r.node = i_node;
                r.k    = i_sample_count;
                r.seed = i_seed;
                predict_samples(r);
            end
            if (o_valid && !i_stall) begin
                n_results++;
                got.neighbor = o_neighbor;
                got.last     = o_last;
                got.status   = t_status'(o_status);
                if (sampled_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result beat: nb=%0d last=%0b st=%0d",
                                 got.neighbor, got.last, got.status);
                    end
                end else begin
                    want = sampled_beats.pop_front();
                    if (got.neighbor !== want.neighbor || got.last !== want.last ||
                        got.status !== want.status) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"mismatch: exp nb=%0d last=%0b st=%0d,",
                                      " got nb=%0d last=%0b st=%0d"},
                                     want.neighbor, want.last, want.status,
                                     got.neighbor, got.last, got.status);
                        end
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus helpers
    task automatic queue_req(input t_opcode op, input logic [17:0] addr,
                             input logic [18:0] data, input logic [15:0] node,
                             input logic [6:0] k, input logic [63:0] seed);
        t_req r;
        r.op = op; r.addr = addr; r.data = data; r.node = node; r.k = k; r.seed = seed;
        if (op == OP_WR_OFFSET && addr <= NODE_LIMIT) begin
            gen_offsets[addr] = data;
        end
        if (op == OP_WR_NEIGHBOR) begin
            gen_nb_written[addr] = 1'b1;
        end
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // true when a sample of this node reads only entries already written
    function automatic bit sample_is_legal(input int unsigned node, input int unsigned k);
        int unsigned lo;
        int unsigned hi;
        int unsigned deg;
        int unsigned kk;
        if (node >= gen_count) begin
            return 1'b1;
        end
        if (!gen_offsets.exists(node) || !gen_offsets.exists(node + 1)) begin
            return 1'b0;
        end
        lo = gen_offsets[node];
        hi = gen_offsets[node + 1];
        deg = (hi > lo) ? hi - lo : 0;
        kk = (k > K_LIMIT) ? K_LIMIT : k;
        if (kk == 0 || deg == 0 || (kk < deg && deg > POOL_SIZE)) begin
            return 1'b1;
        end
        for (int i = 0; i < deg; i++) begin
            if (!gen_nb_written.exists(lo + i)) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic queue_sample(input int unsigned node, input int unsigned k,
                                input logic [63:0] seed);
        if (sample_is_legal(node, k)) begin
            queue_req(OP_SAMPLE, 18'($urandom), 19'($urandom), 16'(node), 7'(k), seed);
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // wait for the block to drain, then reprogram the node count
    task automatic drain_and_configure(input int unsigned users, input int unsigned items);
        while (pending_reqs.size() > 0 || i_valid || sampled_beats.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_USER_COUNT;
        i_cfg_data  <= 17'(users);
        @(negedge i_clk);
        i_cfg_index <= CFG_ITEM_COUNT;
        i_cfg_data  <= 17'(items);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        gen_count = (users + items > NODE_LIMIT) ? NODE_LIMIT : users + items;
        n_phases++;
    endtask

    // random traffic: mostly node builds followed by samples, some noise
    task automatic random_traffic(input int n_items);
        int unsigned node;
        int unsigned deg;
        int unsigned lo;
        int unsigned k;
        int target;
        target = pending_reqs.size() + n_items;
        while (pending_reqs.size() < target) begin
            case ($urandom_range(0, 9))
                0: queue_req(OP_UNUSED, 18'($urandom), 19'($urandom), 16'($urandom),
                             7'($urandom), rand64());
                1: queue_req(OP_WR_OFFSET, 18'($urandom_range(NODE_LIMIT + 1, 262143)),
                             19'($urandom_range(0, 262144)), 16'($urandom), 7'($urandom),
                             rand64());
                2: queue_req(OP_WR_NEIGHBOR, 18'($urandom_range(0, NB_SPAN - 1)),
                             19'($urandom_range(0, 262144)), 16'($urandom), 7'($urandom),
                             rand64());
                3: queue_sample($urandom_range(0, 65535), $urandom_range(0, 127), rand64());
                default: begin
                    if ($urandom_range(0, 1) == 0) begin
                        node = $urandom_range(0, (gen_count > 8) ? 7 : gen_count - 1);
                    end else begin
                        node = gen_count - 1
                             - $urandom_range(0, (gen_count > 8) ? 7 : gen_count - 1);
                    end
                    deg = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 80) : 0;
                    lo  = $urandom_range(0, NB_SPAN - deg);
                    queue_req(OP_WR_OFFSET, 18'(node), 19'(lo), 16'($urandom), 7'($urandom),
                              rand64());
                    queue_req(OP_WR_OFFSET, 18'(node + 1), 19'(lo + deg), 16'($urandom),
                              7'($urandom), rand64());
                    repeat ($urandom_range(1, 3)) begin
                        case ($urandom_range(0, 5))
                            0: k = 0;
                            1: k = deg;
                            2: k = $urandom_range(65, 127);
                            default: k = (deg > 1) ? $urandom_range(1, deg - 1) : 1;
                        endcase
                        queue_sample(node, k, rand64());
                    end
                end
            endcase
        end
    endtask

    // ---------------------------------------------------------------- main sequence
    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_index = 1'b0; i_cfg_data = '0;
        i_valid = 1'b0; i_stall = 1'b0;
        i_opcode = '0; i_table_address = '0; i_table_data = '0;
        i_node = '0; i_sample_count = '0; i_seed = '0;
        pr_users = '0; pr_items = '0; tw_pos = 0;
        send_idle_pct = 38; recv_idle_pct = 65; gen_count = 0;
        mismatches = 0; n_requests = 0; n_results = 0; n_shuffled = 0; n_phases = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty graph: every node is out of range
        drain_and_configure(0, 0);
        queue_sample(0, 5, 64'd0);
        queue_sample(65535, 127, {64{1'b1}});

        // directed: five nodes
        drain_and_configure(3, 2);
        queue_req(OP_WR_NEIGHBOR, 18'd262142, 19'd65535, 16'd0, 7'd0, 64'd0);
        queue_req(OP_WR_NEIGHBOR, 18'd262143, 19'd262144, 16'd0, 7'd0, 64'd0);
        queue_req(OP_WR_OFFSET, 18'd262143, 19'd7, 16'd0, 7'd0, 64'd0);  // ignored write
        queue_req(OP_UNUSED, {18{1'b1}}, {19{1'b1}}, {16{1'b1}}, {7{1'b1}}, {64{1'b1}});
        queue_req(OP_WR_OFFSET, 18'd0, 19'd262142, 16'd0, 7'd0, 64'd0);
        queue_req(OP_WR_OFFSET, 18'd1, 19'd262144, 16'd0, 7'd0, 64'd0);
        queue_req(OP_WR_OFFSET, 18'd2, 19'd262144, 16'd0, 7'd0, 64'd0);
        queue_req(OP_WR_OFFSET, 18'd3, 19'd5, 16'd0, 7'd0, 64'd0);      // end below begin
        queue_req(OP_WR_OFFSET, 18'd4, 19'd1030, 16'd0, 7'd0, 64'd0);   // degree 1025
        queue_req(OP_WR_OFFSET, 18'd5, 19'd1030, 16'd0, 7'd0, 64'd0);
        queue_sample(0, 64, 64'd0);               // whole list at top of table
        queue_sample(0, 127, 64'd1);              // count saturates
        queue_sample(0, 0, 64'd0);                // zero count
        queue_sample(0, 1, {64{1'b1}});           // shuffled
        queue_sample(0, 1, 64'd0);
        queue_sample(1, 3, 64'd0);                // degree zero
        queue_sample(2, 3, 64'd0);                // reversed offsets
        queue_sample(3, 3, 64'h0123_4567_89AB_CDEF);  // pool overflow
        queue_sample(3, 64, 64'd0);
        queue_sample(4, 1, 64'd0);
        queue_sample(5, 1, 64'd0);                // first node past the count
        queue_sample(65535, 1, 64'd0);

        // widest count, sender idles less than the receiver
        drain_and_configure(65536, 65536);
        send_idle_pct = 38; recv_idle_pct = 65;
        for (int i = 0; i < NB_SPAN; i++) begin
            queue_req(OP_WR_NEIGHBOR, 18'(i), 19'($urandom_range(0, 262144)),
                      16'($urandom), 7'($urandom), rand64());
        end
        random_traffic(50);
        // hold off until every result of the first half is back
        while (pending_reqs.size() > 0 || i_valid || sampled_beats.size() > 0) begin
            @(posedge i_clk);
        end
        random_traffic(50);

        drain_and_configure(0, 40);
        send_idle_pct = 65; recv_idle_pct = 38;
        random_traffic(90);

        drain_and_configure(40000, 25535);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_traffic(90);

        while (pending_reqs.size() > 0 || i_valid || sampled_beats.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (30) @(posedge i_clk);
        $display("covered %0d request beats over %0d count settings, %0d shuffled samples,",
                 n_requests, n_phases, n_shuffled);
        $display("%0d result beats checked, %0d mismatches", n_results, mismatches);
        if (mismatches == 0 && sampled_beats.size() == 0) begin
            $display("[csr_neighbor_sampler] OK");
        end else begin
            $display("[csr_neighbor_sampler] ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(12 * 40000000);
        $display("timeout with %0d result beats outstanding", sampled_beats.size());
        $display("[csr_neighbor_sampler] ERROR");
        $finish;
    end

endmodule
`default_nettype wire

[sim.f]
src/cns_pkg.sv
src/cns_ram.sv
src/csr_neighbor_sampler.sv
test/csr_neighbor_sampler_tb.sv
